/* rtl/core/perspective_raster_matrix_macros.svh */
// ----------------------------------------------------------------------------
// perspective raster matrix assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_RASTER_MATRIX_MACROS_SVH
`define PERSPECTIVE_RASTER_MATRIX_MACROS_SVH

// same-cycle implication
`define PRM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/prm_pkg.sv */
// ----------------------------------------------------------------------------
// prm_pkg
// shared types, constants and tables of the perspective raster matrix
// ----------------------------------------------------------------------------
package prm_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
  localparam int TILT_TABLE_DEPTH = 16;
  localparam int TILT_AW          = $clog2(TILT_TABLE_DEPTH);

  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_EYE_HEIGHT      = 3'd0;
  localparam logic [2:0] REG_SCREEN_DISTANCE = 3'd1;
  localparam logic [2:0] REG_GROUND_DISTANCE = 3'd2;
  localparam logic [2:0] REG_HEADING_ANGLE   = 3'd3;
  localparam logic [2:0] REG_TILT_ANGLE      = 3'd4;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF    = 64'd536870912;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] CORR_K1_Q30 = 64'd85131621;
  localparam logic [63:0] CORR_K0_Q30 = 64'd331153790;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // line pipeline layout
  localparam int DIV_STAGES = 16;
  localparam int DIV_DW     = 52;
  localparam int NLANE      = 4;
  localparam int LANE_A     = 0;
  localparam int LANE_B     = 1;
  localparam int LANE_C     = 2;
  localparam int LANE_D     = 3;
  localparam int NSTAGE     = DIV_STAGES + 6;
  localparam int S_PROD     = 0;
  localparam int S_DEN      = 1;
  localparam int S_VM       = 2;
  localparam int S_MUL      = 3;
  localparam int S_SET      = 4;
  localparam int S_DIV0     = 5;
  localparam int S_OUT      = NSTAGE - 1;

  typedef logic signed [16:0] q15_t;
  typedef q15_t sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [15:0] tilt_rom_t [TILT_TABLE_DEPTH];

  localparam tilt_rom_t MAX_TILT = '{
    16'h38b4, 16'h38b7, 16'h38ba, 16'h38be, 16'h38c0, 16'h38c4, 16'h38c7, 16'h38ca,
    16'h38ce, 16'h38d0, 16'h38d4, 16'h38d7, 16'h38da, 16'h38dd, 16'h38e0, 16'h38e4
  };

  typedef struct packed {
    logic signed [15:0] eye;
    logic signed [15:0] sd;
    logic signed [15:0] gd;
    logic [15:0]        heading;
    logic [15:0]        tilt;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] hs;
    logic signed [16:0] hc;
    logic signed [16:0] ts;
    logic signed [31:0] vp;
    logic signed [16:0] cc;
    logic signed [31:0] go;
  } view_t;

  typedef struct packed {
    logic ovf;
    logic neg;
  } div_tag_t;

  // taylor series over one quarter turn, p in [0, 2^30]
  function automatic logic [16:0] quarter_sine(logic [63:0] p);
    logic [63:0] x, x2, t, s;
    x  = (p * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (((x * t) >> 30) + 64'd16384) >> 15;
    return (s > 64'd32768) ? 17'd32768 : s[16:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   r;
    logic [31:0] ph;
    logic [63:0] frac;
    logic [16:0] v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ph   = 32'(i) << (32 - SINE_AW);
      frac = {34'd0, ph[29:0]};
      if (ph[30]) begin
        v = quarter_sine(Q30_ONE - frac);
      end else begin
        v = quarter_sine(frac);
      end
      r[i] = ph[31] ? -$signed(v) : $signed(v);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/core/perspective_raster_matrix.sv */
// ----------------------------------------------------------------------------
// perspective_raster_matrix
// per-scanline 8.8 rotation and perspective scale matrix of a ground plane
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  line      line_valid / line_ready        line_index
//  matrix    matrix_valid / matrix_ready    matrix_a, matrix_b, matrix_c, matrix_d
//  config    psel / penable / pwrite        paddr, pwdata, prdata (pready tied high)
//
// one line per cycle while matrix is not stalled and the view sequencer is idle;
// the depth is set by five front stages, the 16 quotient-bit stages of the
// four divider lanes and the output register
// every write to a defined register and the end of reset start the view
// sequencer, which holds line_ready low while it runs (up to three shift-add products);
// a write during a run adds one more run
// stages advance independently, so bubbles close up while matrix is stalled
// ----------------------------------------------------------------------------
`include "perspective_raster_matrix_macros.svh"

module perspective_raster_matrix (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        line_valid,
  output logic                        line_ready,
  input  logic signed [15:0]          line_index,
  output logic                        matrix_valid,
  input  logic                        matrix_ready,
  output logic signed [15:0]          matrix_a,
  output logic signed [15:0]          matrix_b,
  output logic signed [15:0]          matrix_c,
  output logic signed [15:0]          matrix_d
);
  import prm_pkg::*;

  cfg_t        cfg;
  view_t       view;
  logic        busy;
  logic        init;
  logic        wr;
  logic [2:0]  widx;
  logic        widx_ok;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] mv;

  logic signed [32:0] prod, prod_c;
  logic signed [33:0] dsum;
  logic [33:0]        dabs;
  logic               hz_c;
  logic [34:0]        e_mag, e_mag2, e_mag3;
  logic               e_neg, e_neg2, hz;
  logic [31:0]        vpm;
  logic [38:0]        vm_mag;
  logic               vm_neg;
  logic [15:0]        hsm, hcm;
  logic [16:0]        hs_n, hc_n;
  logic [53:0]        na, nc;
  logic [50:0]        db;
  logic               neg_a, neg_b, neg_c;

  logic [63:0]       n_c    [NLANE];
  logic [DIV_DW-1:0] d_c    [NLANE];
  div_tag_t          t_c    [NLANE];
  logic [63:0]       lane_n [NLANE];
  logic [DIV_DW-1:0] lane_d [NLANE];
  div_tag_t          lane_t [NLANE];
  logic [DIV_STAGES-1:0] lane_q  [NLANE];
  div_tag_t              lane_tq [NLANE];
  logic [15:0]           sat     [NLANE];

  // configuration port
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign widx    = paddr[PADDR_W-1:2];
  assign widx_ok = (widx == REG_EYE_HEIGHT) || (widx == REG_SCREEN_DISTANCE) ||
                   (widx == REG_GROUND_DISTANCE) || (widx == REG_HEADING_ANGLE) ||
                   (widx == REG_TILT_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eye     <= 16'sd256;
      cfg.sd      <= 16'sd256;
      cfg.gd      <= '0;
      cfg.heading <= '0;
      cfg.tilt    <= '0;
      init        <= 1'b1;
    end else begin
      init <= 1'b0;
      if (wr) begin
        case (widx)
          REG_EYE_HEIGHT:      cfg.eye     <= pwdata[15:0];
          REG_SCREEN_DISTANCE: cfg.sd      <= pwdata[15:0];
          REG_GROUND_DISTANCE: cfg.gd      <= pwdata[15:0];
          REG_HEADING_ANGLE:   cfg.heading <= pwdata[15:0];
          REG_TILT_ANGLE:      cfg.tilt    <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (widx)
      REG_EYE_HEIGHT:      prdata = {16'd0, cfg.eye};
      REG_SCREEN_DISTANCE: prdata = {16'd0, cfg.sd};
      REG_GROUND_DISTANCE: prdata = {16'd0, cfg.gd};
      REG_HEADING_ANGLE:   prdata = {16'd0, cfg.heading};
      REG_TILT_ANGLE:      prdata = {16'd0, cfg.tilt};
      default:             prdata = 32'd0;
    endcase
  end

  prm_derive u_derive (
    .clk   (clk),
    .rst   (rst),
    .start (init || (wr && widx_ok)),
    .cfg   (cfg),
    .busy  (busy),
    .view  (view)
  );

  // stage moves when empty or when the stage after it moves
  always_comb begin
    mv[S_OUT] = !vld[S_OUT] || matrix_ready;
    for (int k = S_OUT - 1; k >= 0; k--) begin
      mv[k] = !vld[k] || mv[k+1];
    end
  end

  assign line_ready   = mv[S_PROD] && !busy && !init;
  assign matrix_valid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (mv[S_PROD]) vld[S_PROD] <= line_valid && line_ready;
      for (int k = 1; k < NSTAGE; k++) begin
        if (mv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // datapath
  always_comb begin
    prod_c = $signed(line_index) * view.ts;
    dsum   = 34'(prod) + 34'(view.go);
    dabs   = dsum[33] ? 34'(-dsum) : dsum;
    hz_c   = (dsum > -34'sd33) && (dsum < 34'sd33);
    vpm    = view.vp[31] ? (~view.vp + 32'd1) : view.vp;
    hs_n   = view.hs[16] ? 17'(-view.hs) : view.hs;
    hc_n   = view.hc[16] ? 17'(-view.hc) : view.hc;
    hsm    = hs_n[15:0];
    hcm    = hc_n[15:0];
  end

  always_comb begin
    n_c[LANE_A] = (64'(na) << 1) + (64'(e_mag3) << 7);
    d_c[LANE_A] = DIV_DW'(e_mag3) << 8;
    n_c[LANE_C] = (64'(nc) << 1) + (64'(e_mag3) << 7);
    d_c[LANE_C] = DIV_DW'(e_mag3) << 8;
    n_c[LANE_B] = (64'(nc) << 9) + 64'(db);
    d_c[LANE_B] = DIV_DW'(db) << 1;
    n_c[LANE_D] = (64'(na) << 9) + 64'(db);
    d_c[LANE_D] = DIV_DW'(db) << 1;
    t_c[LANE_A].neg = neg_a;
    t_c[LANE_B].neg = neg_b;
    t_c[LANE_C].neg = neg_c;
    t_c[LANE_D].neg = neg_a;
    for (int i = 0; i < NLANE; i++) begin
      t_c[i].ovf = ({4'b0000, n_c[i]} >= (68'(d_c[i]) << DIV_STAGES));
    end
  end

  always_ff @(posedge clk) begin
    if (mv[S_PROD]) prod <= prod_c;
    if (mv[S_DEN]) begin
      hz    <= hz_c;
      e_mag <= hz_c ? 35'd8192 : {dabs, 1'b0};
      e_neg <= dsum[33];
    end
    if (mv[S_VM]) begin
      vm_mag <= hz ? 39'(vpm) * 39'd125 : 39'(vpm);
      vm_neg <= view.vp[31];
      e_mag2 <= e_mag;
      e_neg2 <= e_neg;
    end
    if (mv[S_MUL]) begin
      na     <= 54'(vm_mag * 55'(hcm));
      nc     <= 54'(vm_mag * 55'(hsm));
      db     <= 51'(e_mag2 * 51'(view.cc[15:0]));
      e_mag3 <= e_mag2;
      neg_a  <= vm_neg ^ e_neg2 ^ view.hc[16];
      neg_c  <= vm_neg ^ e_neg2 ^ view.hs[16];
      neg_b  <= ~(vm_neg ^ view.hs[16]) ^ e_neg2;
    end
    if (mv[S_SET]) begin
      for (int i = 0; i < NLANE; i++) begin
        lane_n[i] <= n_c[i];
        lane_d[i] <= d_c[i];
        lane_t[i] <= t_c[i];
      end
    end
    if (mv[S_OUT]) begin
      matrix_a <= sat[LANE_A];
      matrix_b <= sat[LANE_B];
      matrix_c <= sat[LANE_C];
      matrix_d <= sat[LANE_D];
    end
  end

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    prm_div u_div (
      .clk     (clk),
      .ld      (mv[S_OUT-1:S_DIV0]),
      .n_in    (lane_n[i]),
      .d_in    (lane_d[i]),
      .tag_in  (lane_t[i]),
      .q       (lane_q[i]),
      .tag_out (lane_tq[i])
    );

    // round-half-away quotient saturated to 16 signed bits
    always_comb begin
      if (lane_tq[i].neg) begin
        sat[i] = (lane_tq[i].ovf || lane_q[i] > 16'd32768) ? 16'h8000 : 16'(-lane_q[i]);
      end else begin
        sat[i] = (lane_tq[i].ovf || lane_q[i][15]) ? 16'h7fff : lane_q[i];
      end
    end
  end

  `PRM_ASSERT_IMP(a_busy_blocks_lines, busy, !line_ready, "line taken while view state derives")
  `PRM_ASSERT_NXT(a_accept_enters, line_valid && line_ready, vld[S_PROD], "accepted line lost")
  `PRM_ASSERT_NXT(a_stall_holds, vld[S_OUT-1] && !mv[S_OUT-1], vld[S_OUT-1], "stalled stage dropped")

endmodule

/* rtl/core/prm_derive.sv */
// ----------------------------------------------------------------------------
// prm_derive
// per-frame view state sequencer: table lookups, view-plane height, tilt clip,
// near-limit cosine correction on a shift-add multiplier, ground offset
// ----------------------------------------------------------------------------
module prm_derive (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  prm_pkg::cfg_t  cfg,
  output logic           busy,
  output prm_pkg::view_t view
);
  import prm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HS   = 4'd1;
  localparam logic [3:0] ST_HC   = 4'd2;
  localparam logic [3:0] ST_TS   = 4'd3;
  localparam logic [3:0] ST_TC   = 4'd4;
  localparam logic [3:0] ST_VPM  = 4'd5;
  localparam logic [3:0] ST_VP   = 4'd6;
  localparam logic [3:0] ST_CLIP = 4'd7;
  localparam logic [3:0] ST_CA   = 4'd8;
  localparam logic [3:0] ST_CB   = 4'd9;
  localparam logic [3:0] ST_M1   = 4'd10;
  localparam logic [3:0] ST_M2   = 4'd11;
  localparam logic [3:0] ST_M3   = 4'd12;
  localparam logic [3:0] ST_GO   = 4'd13;

  logic [3:0]         state;
  logic               again;
  logic [15:0]        rom_addr;
  q15_t               rom_q;
  logic signed [32:0] vprod;
  logic signed [17:0] cl;
  logic               corr;
  logic [16:0]        mag;
  logic [63:0]        a2;
  logic [63:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        acc;

  logic signed [34:0] vsum;
  logic signed [31:0] vp_sat;
  logic [31:0]        vpabs;
  logic [15:0]        ip;
  logic [3:0]         lg;
  logic [TILT_AW-1:0] tidx;
  logic signed [17:0] mxs, tsx, cl_c, edge_v, cq, an;
  logic [16:0]        mag_c;
  logic               corr_c;
  logic signed [16:0] cc_raw;
  logic [63:0]        acc_hi;
  logic [63:0]        nc;
  logic signed [32:0] go_prod;

  assign busy = (state != ST_IDLE) || again;

  always_comb begin
    case (state)
      ST_HS:   rom_addr = cfg.heading;
      ST_HC:   rom_addr = cfg.heading + QUARTER_TURN;
      ST_TS:   rom_addr = cfg.tilt;
      ST_TC:   rom_addr = cfg.tilt + QUARTER_TURN;
      ST_CA:   rom_addr = cl[15:0] + QUARTER_TURN;
      default: rom_addr = cfg.heading;
    endcase
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr[15 -: SINE_AW]];
  end

  // view-plane height with saturation to 32 bits
  always_comb begin
    vsum = (35'(cfg.eye) <<< 16) + (35'(vprod) <<< 1);
    if (vsum > 35'sd2147483647) begin
      vp_sat = 32'sh7fffffff;
    end else if (vsum < -35'sd2147483648) begin
      vp_sat = 32'sh80000000;
    end else begin
      vp_sat = vsum[31:0];
    end
  end

  // clip index from the integer part of |vp|, then tilt clip
  always_comb begin
    vpabs = view.vp[31] ? (~view.vp + 32'd1) : view.vp;
    ip    = vpabs[31:16];
    lg    = 4'd0;
    for (int i = 1; i < 15; i++) begin
      if ((ip >> i) != 16'd0) lg = 4'(i);
    end
    tidx   = (ip == 16'd0) ? TILT_AW'(15) : TILT_AW'(4'd14 - lg);
    mxs    = {2'b00, MAX_TILT[tidx]};
    tsx    = 18'($signed(cfg.tilt));
    cl_c   = tsx;
    if (tsx[17]) begin
      if (tsx < 18'sd1 - mxs) cl_c = 18'sd1 - mxs;
    end else if (tsx > mxs) begin
      cl_c = mxs;
    end
    edge_v = tsx[17] ? -$signed({2'b00, MAX_TILT[0]}) : $signed({2'b00, MAX_TILT[0]});
    corr_c = (tsx != cl_c) || (tsx == edge_v);
    cq     = tsx - cl_c;
    if (!cq[17]) cq = cq - 18'sd1;
    an     = -(cq <<< 2) - 18'sd1;
    mag_c  = an[17] ? 17'(-an) : an[16:0];
  end

  always_comb begin
    cc_raw  = (rom_q < 17'sd1) ? 17'sd1 : rom_q;
    acc_hi  = acc >> 30;
    nc      = {47'd0, view.cc} + acc_hi;
    go_prod = $signed(cfg.gd) * view.cc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      again   <= 1'b0;
      view.hs <= '0;
      view.hc <= 17'sd32768;
      view.ts <= '0;
      view.vp <= 32'sh02000000;
      view.cc <= 17'sd32768;
      view.go <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start || again) begin
            state <= ST_HS;
            again <= 1'b0;
          end
        end
        ST_HS: state <= ST_HC;
        ST_HC: begin
          view.hs <= rom_q;
          state   <= ST_TS;
        end
        ST_TS: begin
          view.hc <= rom_q;
          state   <= ST_TC;
        end
        ST_TC: begin
          view.ts <= rom_q;
          state   <= ST_VPM;
        end
        ST_VPM: begin
          vprod <= $signed(cfg.sd) * rom_q;
          state <= ST_VP;
        end
        ST_VP: begin
          view.vp <= vp_sat;
          state   <= ST_CLIP;
        end
        ST_CLIP: begin
          cl    <= cl_c;
          corr  <= corr_c;
          mag   <= mag_c;
          state <= ST_CA;
        end
        ST_CA: state <= ST_CB;
        ST_CB: begin
          view.cc <= cc_raw;
          a2      <= 64'(mag) * 64'(mag);
          mul_a   <= 64'(mag) * 64'(mag);
          mul_b   <= CORR_K1_Q30[31:0];
          acc     <= Q30_HALF;
          state   <= corr ? ST_M1 : ST_GO;
        end
        ST_M1, ST_M2, ST_M3: begin
          if (mul_b != 32'd0) begin
            if (mul_b[0]) acc <= acc + mul_a;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else if (state == ST_M1) begin
            mul_a <= a2;
            mul_b <= 32'(acc_hi + CORR_K0_Q30);
            acc   <= Q30_HALF;
            state <= ST_M2;
          end else if (state == ST_M2) begin
            mul_a <= acc_hi;
            mul_b <= 32'(view.cc[15:0]);
            acc   <= Q30_HALF;
            state <= ST_M3;
          end else begin
            view.cc <= (nc > 64'd65535) ? 17'sd65535 : $signed(nc[16:0]);
            state   <= ST_GO;
          end
        end
        ST_GO: begin
          view.go <= go_prod[31:0];
          state   <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      // a write during a run is picked up by one more run
      if (start && state != ST_IDLE) again <= 1'b1;
    end
  end

endmodule

/* rtl/core/prm_div.sv */
// ----------------------------------------------------------------------------
// prm_div
// one lane of the pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module prm_div (
  input  logic                       clk,
  input  logic [prm_pkg::DIV_STAGES-1:0] ld,
  input  logic [63:0]                n_in,
  input  logic [prm_pkg::DIV_DW-1:0] d_in,
  input  prm_pkg::div_tag_t          tag_in,
  output logic [prm_pkg::DIV_STAGES-1:0] q,
  output prm_pkg::div_tag_t          tag_out
);
  import prm_pkg::*;

  logic [63:0]            rem [DIV_STAGES];
  logic [DIV_DW-1:0]      dv  [DIV_STAGES];
  logic [DIV_STAGES-1:0]  qv  [DIV_STAGES];
  div_tag_t               tg  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
    logic [63:0]           rp;
    logic [DIV_DW-1:0]     dp;
    logic [DIV_STAGES-1:0] qp;
    div_tag_t              tp;
    logic [67:0]           dsh;
    logic                  ge;

    if (j == 0) begin : g_first
      assign rp = n_in;
      assign dp = d_in;
      assign qp = '0;
      assign tp = tag_in;
    end else begin : g_next
      assign rp = rem[j-1];
      assign dp = dv[j-1];
      assign qp = qv[j-1];
      assign tp = tg[j-1];
    end

    assign dsh = 68'(dp) << (DIV_STAGES - 1 - j);
    assign ge  = ({4'b0000, rp} >= dsh);

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem[j] <= ge ? (rp - dsh[63:0]) : rp;
        dv[j]  <= dp;
        qv[j]  <= {qp[DIV_STAGES-2:0], ge};
        tg[j]  <= tp;
      end
    end
  end

  assign q       = qv[DIV_STAGES-1];
  assign tag_out = tg[DIV_STAGES-1];

endmodule

/* bench/perspective_raster_matrix_tb.sv */
// ----------------------------------------------------------------------------
// perspective_raster_matrix_tb
// drives scanline transactions under a series of view settings written over
// the register port, predicts the four matrix words of every line and checks
// each matrix transaction against the oldest prediction
// ----------------------------------------------------------------------------
module perspective_raster_matrix_tb;
  import prm_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic line_valid = 1'b0;
  logic line_ready;
  logic signed [15:0] line_index = '0;
  logic matrix_valid;
  logic matrix_ready = 1'b0;
  logic signed [15:0] matrix_a, matrix_b, matrix_c, matrix_d;

  perspective_raster_matrix i_dut (.*);

  always #5 clk = ~clk;

  // view settings and derived per-frame values
  int eye_h, scr_dist, gnd_dist;
  logic [15:0] heading, tilt;
  int hd_sin, hd_cos, tl_sin, vplane, tilt_cos, gnd_off;

  logic signed [15:0] pending_lines[$];
  matrix_t expected_matrices[$];
  int errors = 0;
  int matrices_seen = 0;
  bit reg_activity = 1'b0;

  function automatic int taylor_sine(longint unsigned p);
    longint unsigned x, x2, t, s;
    x = (p * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE - x2 / 110;
    t = Q30_ONE - ((x2 * t) >> 30) / 72;
    t = Q30_ONE - ((x2 * t) >> 30) / 42;
    t = Q30_ONE - ((x2 * t) >> 30) / 20;
    t = Q30_ONE - ((x2 * t) >> 30) / 6;
    s = (((x * t) >> 30) + 16384) >> 15;
    return (s > 32768) ? 32768 : int'(s);
  endfunction

  function automatic int sine_of(logic [15:0] ang);
    logic [31:0] ph;
    int v;
    ph = {ang[15:6], 22'd0};
    if (ph[30]) v = taylor_sine(Q30_ONE - longint'(ph[29:0]));
    else v = taylor_sine(longint'(ph[29:0]));
    return ph[31] ? -v : v;
  endfunction

  function automatic void derive_view();
    longint vp, ip, cq, an;
    longint unsigned mag, a2, aux2, f, nc;
    int tcos, idx, lg, mx, ts, cl, cc, lim_edge;
    hd_sin = sine_of(heading);
    hd_cos = sine_of(heading + QUARTER_TURN);
    tl_sin = sine_of(tilt);
    tcos = sine_of(tilt + QUARTER_TURN);
    vp = longint'(eye_h) * 65536 + longint'(scr_dist) * tcos * 2;
    if (vp > 64'sd2147483647) vp = 64'sd2147483647;
    if (vp < -64'sd2147483648) vp = -64'sd2147483648;
    vplane = int'(vp);
    ip = (vp < 0 ? -vp : vp) >>> 16;
    idx = 15;
    if (ip != 0) begin
      lg = 0;
      while (lg < 14 && (longint'(2) << lg) <= ip) lg++;
      idx = 14 - lg;
    end
    mx = MAX_TILT[idx];
    ts = int'($signed(tilt));
    cl = ts;
    if (ts < 0) begin
      if (ts < -mx + 1) cl = -mx + 1;
    end else if (ts > mx) begin
      cl = mx;
    end
    cc = sine_of(16'(cl) + QUARTER_TURN);
    if (cc < 1) cc = 1;
    lim_edge = ts < 0 ? -int'(MAX_TILT[0]) : int'(MAX_TILT[0]);
    // near the tilt limit the cosine gets a series correction
    if (ts != cl || ts == lim_edge) begin
      cq = longint'(ts) - cl;
      if (cq >= 0) cq -= 1;
      an = -4 * cq - 1;
      mag = an < 0 ? -an : an;
      a2 = mag * mag;
      aux2 = ((a2 * CORR_K1_Q30 + Q30_HALF) >> 30) + CORR_K0_Q30;
      f = (a2 * aux2 + Q30_HALF) >> 30;
      nc = longint'(cc) + ((f * longint'(cc) + Q30_HALF) >> 30);
      if (nc > 65535) nc = 65535;
      cc = int'(nc);
    end
    tilt_cos = cc;
    gnd_off = gnd_dist * cc;
  endfunction

  function automatic logic signed [15:0] round_div_sat(longint n, longint d);
    bit neg;
    longint unsigned un, ud, q;
    if (d == 0) return 16'sd0;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    if (neg) return q > 32768 ? -16'sd32768 : 16'(-longint'(q));
    return q > 32767 ? 16'sd32767 : 16'(q);
  endfunction

  function automatic matrix_t predict_matrix(logic signed [15:0] line);
    longint den, m, e, vm;
    matrix_t r;
    den = longint'(line) * tl_sin + gnd_off;
    // horizon line: denominator forced to +-0.001
    if (den > -33 && den < 33) begin
      m = 125;
      e = den < 0 ? -8192 : 8192;
    end else begin
      m = 1;
      e = 2 * den;
    end
    vm = longint'(vplane) * m;
    r.a = round_div_sat(vm * hd_cos, 128 * e);
    r.b = round_div_sat(-256 * vm * hd_sin, e * tilt_cos);
    r.c = round_div_sat(vm * hd_sin, 128 * e);
    r.d = round_div_sat(256 * vm * hd_cos, e * tilt_cos);
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_activity <= ~reg_activity;
    case (idx)
      REG_EYE_HEIGHT: eye_h = int'($signed(val));
      REG_SCREEN_DISTANCE: scr_dist = int'($signed(val));
      REG_GROUND_DISTANCE: gnd_dist = int'($signed(val));
      REG_HEADING_ANGLE: heading = val;
      REG_TILT_ANGLE: tilt = val;
      default: return;
    endcase
    derive_view();
  endtask

  task automatic set_view(logic [15:0] e, logic [15:0] s, logic [15:0] g,
                          logic [15:0] h, logic [15:0] t);
    write_reg(REG_EYE_HEIGHT, e);
    write_reg(REG_SCREEN_DISTANCE, s);
    write_reg(REG_GROUND_DISTANCE, g);
    write_reg(REG_HEADING_ANGLE, h);
    write_reg(REG_TILT_ANGLE, t);
  endtask

  task automatic wait_idle();
    while (pending_lines.size() != 0 || line_valid || expected_matrices.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] random_tilt();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h38a8, 16'h38f0));
      1: return -16'($urandom_range(16'h38a8, 16'h38f0));
      2: return 16'($urandom_range(0, 16'h3000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_line();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 64)) - 16'd32;
      1: return 16'($urandom_range(0, 480)) - 16'd240;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  int lines_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else begin
      if (line_valid && line_ready) begin
        expected_matrices.push_back(predict_matrix(line_index));
        lines_done++;
      end
      if (!(line_valid && !line_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          line_valid <= 1'b0;
        end else if (pending_lines.size() != 0) begin
          line_valid <= 1'b1;
          line_index <= pending_lines.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          line_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: cycles through four stall patterns, one long hold-off
  int ready_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  matrix_t exp_m;
  always @(posedge clk) begin
    if (rst) begin
      matrix_ready <= 1'b0;
    end else begin
      if (matrix_valid && matrix_ready) begin
        matrices_seen++;
        if (expected_matrices.size() == 0) begin
          errors++;
          $error("matrix transaction with no line pending");
        end else begin
          exp_m = expected_matrices.pop_front();
          if (matrix_a !== exp_m.a) begin
            errors++;
            $error("matrix_a expected %0d actual %0d", exp_m.a, matrix_a);
          end
          if (matrix_b !== exp_m.b) begin
            errors++;
            $error("matrix_b expected %0d actual %0d", exp_m.b, matrix_b);
          end
          if (matrix_c !== exp_m.c) begin
            errors++;
            $error("matrix_c expected %0d actual %0d", exp_m.c, matrix_c);
          end
          if (matrix_d !== exp_m.d) begin
            errors++;
            $error("matrix_d expected %0d actual %0d", exp_m.d, matrix_d);
          end
        end
      end
      ready_cycle++;
      if (!hold_done && lines_done >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        matrix_ready <= 1'b0;
      end else begin
        case ((ready_cycle / 64) % 4)
          0: matrix_ready <= 1'b1;
          1: matrix_ready <= ($urandom_range(0, 1) == 1);
          2: matrix_ready <= ($urandom_range(0, 9) == 0);
          default: matrix_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;
  bit last_reg_activity = 1'b0;
  always @(posedge clk) begin
    if ((line_valid && line_ready) || (matrix_valid && matrix_ready) ||
        reg_activity != last_reg_activity || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    last_reg_activity <= reg_activity;
  end

  initial begin
    eye_h = 256;
    scr_dist = 256;
    gnd_dist = 0;
    heading = '0;
    tilt = '0;
    derive_view();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    // directed: reset view, extremes of the line, horizon at line zero
    pending_lines = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1};
    wait_idle();
    // unknown register index is ignored
    write_reg(REG_UNUSED, 16'h1234);
    pending_lines = '{16'sd5};
    wait_idle();
    set_view(16'h7fff, 16'h7fff, 16'h8000, 16'h4000, 16'h38b4);
    pending_lines = '{16'sh8000, 16'sh7fff, 16'sd0};
    wait_idle();
    set_view(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'hc74c);
    pending_lines = '{16'sh8000, 16'sh7fff, 16'sd3};
    wait_idle();
    set_view(16'h0000, 16'h0001, 16'h0000, 16'hc000, 16'h7fff);
    pending_lines = '{16'sd0, -16'sd7, 16'sh7fff};
    wait_idle();
    set_view(16'h0001, 16'h0000, 16'hffff, 16'hffff, 16'h8000);
    pending_lines = '{16'sd0, 16'sd1, 16'sh8000};
    wait_idle();
    set_view(16'h0100, 16'h0100, 16'h0020, 16'h2000, 16'h3900);
    pending_lines = '{16'sd0, -16'sd1, 16'sd100};
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      set_view(16'($urandom), 16'($urandom), 16'($urandom_range(0, 1) ?
               16'($urandom_range(0, 64)) - 16'd32 : 16'($urandom)),
               16'($urandom), random_tilt());
      for (int k = 0; k < 150; k++) pending_lines.push_back(random_line());
      wait_idle();
    end

    if (expected_matrices.size() != 0) begin
      errors++;
      $error("%0d matrix transactions missing", expected_matrices.size());
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
